>>> design/weighted_line_fit_macros.svh
// Assertion macros used by the weighted line fit back end
`ifndef WEIGHTED_LINE_FIT_MACROS_SVH
`define WEIGHTED_LINE_FIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define WLF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("weighted_line_fit: same-cycle check failed");

// Next-cycle implication, disabled while reset is low
`define WLF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("weighted_line_fit: next-cycle check failed");

`endif

>>> design/wlf_pkg.sv
// Shared constants and types of the weighted line fit
`default_nettype none

package wlf_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_POINTS_DEF = 128;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int DIV_CNT_W      = 8;

    // Classified point as it travels from the front to the back
    typedef struct packed {
        logic        acc;
        logic        last;
        logic        xn;
        logic        yn;
        logic [31:0] xm;
        logic [31:0] ym;
        logic [31:0] sigma;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
        logic [127:0]         num;
        logic [127:0]         den;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] q;
    } t_div_rsp;

endpackage

`default_nettype wire

>>> design/wlf_front.sv
// Input side: accepts points, counts the set and classifies each point
`default_nettype none

module wlf_front #(
    parameter int MAX_POINTS = wlf_pkg::MAX_POINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire logic signed [31:0]  i_x_value,
    input  wire logic signed [31:0]  i_y_value,
    input  wire logic        [31:0]  i_y_sigma,
    input  wire logic                i_last_point,
    input  wire logic                i_q_full,
    output logic                     o_q_push,
    output wlf_pkg::t_item           o_item
);
    import wlf_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      xu;
    logic [31:0]      yu;

    assign xu       = i_x_value;
    assign yu       = i_y_value;
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_item.acc   = r_cnt < CNT_W'(MAX_POINTS);
        o_item.last  = i_last_point;
        o_item.xn    = xu[31];
        o_item.yn    = yu[31];
        o_item.xm    = xu[31] ? (~xu + 32'd1) : xu;
        o_item.ym    = yu[31] ? (~yu + 32'd1) : yu;
        o_item.sigma = i_y_sigma;
    end

    // Points past the limit still pass, flagged as not accumulated
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (o_q_push) begin
            if (i_last_point) begin
                r_cnt <= '0;
            end else if (o_item.acc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/wlf_fifo.sv
// Short queue of classified points between front and back
`default_nettype none

module wlf_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wlf_pkg::t_item      i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output wlf_pkg::t_item      o_item
);
    import wlf_pkg::*;

    localparam int CW = $clog2(QDEPTH + 1);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [CW-1:0]     r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_cnt == CW'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/wlf_mul.sv
// Shared 64x64 unsigned multiplier, one 32x32 partial product a cycle
`default_nettype none

module wlf_mul (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wlf_pkg::t_mul_req i_req,
    output wlf_pkg::t_mul_rsp o_rsp
);
    import wlf_pkg::*;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [1:0]   r_psh;
    logic         r_pv;
    logic [2:0]   r_ph;
    logic         r_busy;
    logic         r_done;
    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  n_pp;
    logic [1:0]   n_psh;
    logic [127:0] addend;

    assign a_part = r_ph[1] ? r_a[63:32] : r_a[31:0];
    assign b_part = r_ph[0] ? r_b[63:32] : r_b[31:0];
    assign n_pp   = a_part * b_part;
    assign n_psh  = 2'(r_ph[1]) + 2'(r_ph[0]);
    assign addend = {64'd0, r_pp} << {r_psh, 5'd0};

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph   <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_ph   <= '0;
                r_pv   <= 1'b0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // fold the previous partial product while forming the next
                if (r_pv) begin
                    r_acc <= r_acc + addend;
                end
                if (r_ph != 3'd4) begin
                    r_pp  <= n_pp;
                    r_psh <= n_psh;
                    r_pv  <= 1'b1;
                    r_ph  <= r_ph + 3'd1;
                end else begin
                    r_pv   <= 1'b0;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/wlf_div.sv
// Shared restoring divider, one quotient bit a cycle, saturating 64-bit quotient
`default_nettype none

module wlf_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wlf_pkg::t_div_req i_req,
    output wlf_pkg::t_div_rsp o_rsp
);
    import wlf_pkg::*;

    logic [127:0]         r_rem;
    logic [127:0]         r_num;
    logic [127:0]         r_den;
    logic [63:0]          r_q;
    logic                 r_sat;
    logic                 r_dz;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [127:0]         sh;
    logic [127:0]         diff;
    logic                 ge;

    assign sh   = {r_rem[126:0], r_num[127]};
    assign ge   = r_rem[127] || (sh >= r_den);
    assign diff = sh - r_den;

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.q    = (r_sat || r_dz) ? '1 : r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_q    <= '0;
                r_sat  <= 1'b0;
                r_dz   <= i_req.den == '0;
                r_cnt  <= i_req.iters;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? diff : sh;
                r_num <= {r_num[126:0], 1'b0};
                // a bit shifted out of the quotient means overflow
                r_sat <= r_sat | r_q[63];
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> design/wlf_back.sv
// Back end: weights, accumulates, solves the fit and holds the result
`default_nettype none
`include "weighted_line_fit_macros.svh"

module wlf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    input  wlf_pkg::t_item     i_item,
    output wlf_pkg::t_mul_req  o_mul_req,
    input  wlf_pkg::t_mul_rsp  i_mul_rsp,
    output wlf_pkg::t_div_req  o_div_req,
    input  wlf_pkg::t_div_rsp  i_div_rsp,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic               o_fit_ok,
    output logic signed [31:0] o_intercept,
    output logic signed [31:0] o_slope,
    output logic        [31:0] o_intercept_error,
    output logic        [31:0] o_slope_error,
    output logic signed [63:0] o_determinant
);
    import wlf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_WQ, S_MX, S_MXW, S_MYW, S_XX1, S_XX2, S_XY1, S_XY2,
        S_NEXT, S_P1, S_P1W, S_P2W, S_SUB, S_MAG, S_QW, S_EW, S_ROOT, S_OUT, S_FAIL
    } t_state;

    typedef enum logic [2:0] {J_DET, J_NA, J_NB, J_EA, J_EB} t_job;
    typedef enum logic [2:0] {T_W, T_X, T_Y, T_XX, T_XY} t_tgt;

    localparam int SH1 = FRAC_BITS;
    localparam int SH2 = 2 * FRAC_BITS;
    localparam int DUP = (2 * FRAC_BITS <= 32) ? 32 - 2 * FRAC_BITS : 0;
    localparam int DDN = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam logic [DIV_CNT_W-1:0] IT_W = DIV_CNT_W'(3 * FRAC_BITS + 1);
    localparam logic [DIV_CNT_W-1:0] IT_Q = DIV_CNT_W'(128 + FRAC_BITS);
    localparam logic [DIV_CNT_W-1:0] IT_E = DIV_CNT_W'(64 + 3 * FRAC_BITS);
    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [31:0] W_MAX   = 32'hFFFF_FFFF;
    localparam logic [63:0] DET_FAIL = 64'hFFFF_FFFF_0000_0000;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? S64_MIN : S64_MAX;
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] to_s64(input logic neg, input logic [127:0] m);
        if (m[127:63] != '0) begin
            to_s64 = neg ? S64_MIN : S64_MAX;
        end else begin
            to_s64 = neg ? (~m[63:0] + 64'd1) : m[63:0];
        end
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] u;
        u = v;
        mag64 = u[63] ? (~u + 64'd1) : u;
    endfunction

    function automatic logic [31:0] sat_s32(input logic neg, input logic [63:0] q);
        if (neg) begin
            sat_s32 = (q >= 64'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
        end else begin
            sat_s32 = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
    endfunction

    function automatic logic [128:0] sgn129(input logic neg, input logic [127:0] m);
        sgn129 = neg ? (~{1'b0, m} + 129'd1) : {1'b0, m};
    endfunction

    t_state               r_state;
    t_job                 r_job;
    t_tgt                 r_tgt;
    t_item                r_item;
    logic [31:0]          r_w;
    logic signed [63:0]   r_term;
    logic                 r_term_v;
    logic signed [63:0]   r_sum_w;
    logic signed [63:0]   r_sum_x;
    logic signed [63:0]   r_sum_y;
    logic signed [63:0]   r_sum_xx;
    logic signed [63:0]   r_sum_xy;
    logic                 r_mul_start;
    logic [63:0]          r_ma;
    logic [63:0]          r_mb;
    logic                 r_pneg;
    logic                 r_div_start;
    logic [DIV_CNT_W-1:0] r_div_iters;
    logic [127:0]         r_div_num;
    logic [127:0]         r_div_den;
    logic [128:0]         r_p1;
    logic [128:0]         r_p2;
    logic [128:0]         r_diff;
    logic [127:0]         r_det;
    logic                 r_nneg;
    logic [31:0]          r_icpt;
    logic [31:0]          r_slope;
    logic [31:0]          r_ierr;
    logic [31:0]          r_serr;
    logic [63:0]          r_rv;
    logic [63:0]          r_res;
    logic [63:0]          r_bit;
    logic                 r_out_valid;
    logic                 r_o_ok;
    logic [31:0]          r_o_icpt;
    logic [31:0]          r_o_slope;
    logic [31:0]          r_o_ierr;
    logic [31:0]          r_o_serr;
    logic [63:0]          r_o_det;

    logic signed [63:0]   p1a;
    logic signed [63:0]   p1b;
    logic signed [63:0]   p2b;
    logic [128:0]         n_abs;
    logic [127:0]         n_mag;
    logic                 n_neg;
    logic [63:0]          n_sum;
    logic                 n_ge;
    logic [63:0]          n_rv;
    logic [63:0]          n_res;
    logic [127:0]         det_sh;
    logic [63:0]          det_q32;
    logic                 out_load;
    logic [31:0]          n_w;

    assign o_q_pop  = (r_state == S_IDLE) && !i_q_empty;
    assign out_load = ((r_state == S_OUT) || (r_state == S_FAIL)) && !r_out_valid;

    assign o_mul_req.start = r_mul_start;
    assign o_mul_req.a     = r_ma;
    assign o_mul_req.b     = r_mb;
    assign o_div_req.start = r_div_start;
    assign o_div_req.iters = r_div_iters;
    assign o_div_req.num   = r_div_num;
    assign o_div_req.den   = r_div_den;

    assign o_empty           = !r_out_valid;
    assign o_fit_ok          = r_o_ok;
    assign o_intercept       = r_o_icpt;
    assign o_slope           = r_o_slope;
    assign o_intercept_error = r_o_ierr;
    assign o_slope_error     = r_o_serr;
    assign o_determinant     = r_o_det;

    assign n_w = (i_div_rsp.q[63:32] != '0) ? W_MAX : i_div_rsp.q[31:0];

    // Operand pairs: det = S*Sxx - Sx*Sx, na = Sxx*Sy - Sx*Sxy, nb = Sxy*S - Sx*Sy
    always_comb begin
        case (r_job)
            J_NA: begin
                p1a = r_sum_xx;
                p1b = r_sum_y;
                p2b = r_sum_xy;
            end
            J_NB: begin
                p1a = r_sum_xy;
                p1b = r_sum_w;
                p2b = r_sum_y;
            end
            default: begin
                p1a = r_sum_w;
                p1b = r_sum_xx;
                p2b = r_sum_x;
            end
        endcase
    end

    assign n_neg = r_diff[128];
    assign n_abs = n_neg ? (~r_diff + 129'd1) : r_diff;
    assign n_mag = n_abs[127:0];

    // Digit-by-digit square root step
    assign n_sum = r_res + r_bit;
    assign n_ge  = r_rv >= n_sum;
    assign n_rv  = r_rv - n_sum;
    assign n_res = n_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // Rescale the determinant from Q.2F to Q32.32
    assign det_sh  = r_det >> DDN;
    assign det_q32 = ((det_sh[127:64] != '0) || (det_sh[63:0] > (S64_MAX >> DUP)))
                     ? S64_MAX : (det_sh[63:0] << DUP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_DET;
            r_tgt       <= T_W;
            r_term_v    <= 1'b0;
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_w     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xx    <= '0;
            r_sum_xy    <= '0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;

            // accumulate a pending term into its sum
            if (r_term_v) begin
                r_term_v <= 1'b0;
                case (r_tgt)
                    T_W:     r_sum_w  <= sat_add(r_sum_w, r_term);
                    T_X:     r_sum_x  <= sat_add(r_sum_x, r_term);
                    T_Y:     r_sum_y  <= sat_add(r_sum_y, r_term);
                    T_XX:    r_sum_xx <= sat_add(r_sum_xx, r_term);
                    T_XY:    r_sum_xy <= sat_add(r_sum_xy, r_term);
                    default: r_sum_w  <= r_sum_w;
                endcase
            end

            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_item <= i_item;
                        if (i_item.acc) begin
                            if (i_item.sigma == '0) begin
                                r_w      <= W_MAX;
                                r_term   <= {32'd0, W_MAX};
                                r_tgt    <= T_W;
                                r_term_v <= 1'b1;
                                r_state  <= S_MX;
                            end else begin
                                r_ma        <= {32'd0, i_item.sigma};
                                r_mb        <= {32'd0, i_item.sigma};
                                r_mul_start <= 1'b1;
                                r_state     <= S_SQ;
                            end
                        end else if (i_item.last) begin
                            r_job   <= J_DET;
                            r_state <= S_P1;
                        end
                    end
                end
                S_SQ: begin
                    if (i_mul_rsp.done) begin
                        r_div_num   <= {1'b1, 127'd0};
                        r_div_den   <= {64'd0, i_mul_rsp.prod[63:0]};
                        r_div_iters <= IT_W;
                        r_div_start <= 1'b1;
                        r_state     <= S_WQ;
                    end
                end
                S_WQ: begin
                    if (i_div_rsp.done) begin
                        r_w      <= n_w;
                        r_term   <= {32'd0, n_w};
                        r_tgt    <= T_W;
                        r_term_v <= 1'b1;
                        r_state  <= S_MX;
                    end
                end
                S_MX: begin
                    r_ma        <= {32'd0, r_w};
                    r_mb        <= {32'd0, r_item.xm};
                    r_mul_start <= 1'b1;
                    r_state     <= S_MXW;
                end
                S_MXW: begin
                    if (i_mul_rsp.done) begin
                        r_term      <= to_s64(r_item.xn, i_mul_rsp.prod >> SH1);
                        r_tgt       <= T_X;
                        r_term_v    <= 1'b1;
                        r_ma        <= {32'd0, r_w};
                        r_mb        <= {32'd0, r_item.ym};
                        r_mul_start <= 1'b1;
                        r_state     <= S_MYW;
                    end
                end
                S_MYW: begin
                    if (i_mul_rsp.done) begin
                        r_term      <= to_s64(r_item.yn, i_mul_rsp.prod >> SH1);
                        r_tgt       <= T_Y;
                        r_term_v    <= 1'b1;
                        r_ma        <= {32'd0, r_item.xm};
                        r_mb        <= {32'd0, r_item.xm};
                        r_mul_start <= 1'b1;
                        r_state     <= S_XX1;
                    end
                end
                S_XX1: begin
                    if (i_mul_rsp.done) begin
                        r_ma        <= {32'd0, r_w};
                        r_mb        <= i_mul_rsp.prod[63:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_XX2;
                    end
                end
                S_XX2: begin
                    if (i_mul_rsp.done) begin
                        r_term      <= to_s64(1'b0, i_mul_rsp.prod >> SH2);
                        r_tgt       <= T_XX;
                        r_term_v    <= 1'b1;
                        r_ma        <= {32'd0, r_item.xm};
                        r_mb        <= {32'd0, r_item.ym};
                        r_mul_start <= 1'b1;
                        r_state     <= S_XY1;
                    end
                end
                S_XY1: begin
                    if (i_mul_rsp.done) begin
                        r_ma        <= {32'd0, r_w};
                        r_mb        <= i_mul_rsp.prod[63:0];
                        r_mul_start <= 1'b1;
                        r_state     <= S_XY2;
                    end
                end
                S_XY2: begin
                    if (i_mul_rsp.done) begin
                        r_term   <= to_s64(r_item.xn ^ r_item.yn, i_mul_rsp.prod >> SH2);
                        r_tgt    <= T_XY;
                        r_term_v <= 1'b1;
                        r_state  <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    // the last term lands in its sum at this edge
                    if (r_item.last) begin
                        r_job   <= J_DET;
                        r_state <= S_P1;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_P1: begin
                    r_ma        <= mag64(p1a);
                    r_mb        <= mag64(p1b);
                    r_pneg      <= p1a[63] ^ p1b[63];
                    r_mul_start <= 1'b1;
                    r_state     <= S_P1W;
                end
                S_P1W: begin
                    if (i_mul_rsp.done) begin
                        r_p1        <= sgn129(r_pneg, i_mul_rsp.prod);
                        r_ma        <= mag64(r_sum_x);
                        r_mb        <= mag64(p2b);
                        r_pneg      <= r_sum_x[63] ^ p2b[63];
                        r_mul_start <= 1'b1;
                        r_state     <= S_P2W;
                    end
                end
                S_P2W: begin
                    if (i_mul_rsp.done) begin
                        r_p2    <= sgn129(r_pneg, i_mul_rsp.prod);
                        r_state <= S_SUB;
                    end
                end
                S_SUB: begin
                    r_diff  <= r_p1 - r_p2;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    case (r_job)
                        J_DET: begin
                            r_det <= n_mag;
                            if (n_neg || (n_mag == '0)) begin
                                r_state <= S_FAIL;
                            end else begin
                                r_job   <= J_NA;
                                r_state <= S_P1;
                            end
                        end
                        J_NA, J_NB: begin
                            r_nneg      <= n_neg;
                            r_div_num   <= n_mag;
                            r_div_den   <= r_det;
                            r_div_iters <= IT_Q;
                            r_div_start <= 1'b1;
                            r_state     <= S_QW;
                        end
                        default: begin
                            r_state <= S_FAIL;
                        end
                    endcase
                end
                S_QW: begin
                    if (i_div_rsp.done) begin
                        if (r_job == J_NA) begin
                            r_icpt  <= sat_s32(r_nneg, i_div_rsp.q);
                            r_job   <= J_NB;
                            r_state <= S_P1;
                        end else begin
                            r_slope     <= sat_s32(r_nneg, i_div_rsp.q);
                            r_div_num   <= {mag64(r_sum_xx), 64'd0};
                            r_div_den   <= r_det;
                            r_div_iters <= IT_E;
                            r_div_start <= 1'b1;
                            r_job       <= J_EA;
                            r_state     <= S_EW;
                        end
                    end
                end
                S_EW: begin
                    if (i_div_rsp.done) begin
                        r_rv    <= i_div_rsp.q;
                        r_res   <= '0;
                        r_bit   <= {2'b01, 62'd0};
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    if (n_ge) begin
                        r_rv <= n_rv;
                    end
                    if (r_bit[0]) begin
                        if (r_job == J_EA) begin
                            r_ierr      <= n_res[31:0];
                            r_div_num   <= {mag64(r_sum_w), 64'd0};
                            r_div_den   <= r_det;
                            r_div_iters <= IT_E;
                            r_div_start <= 1'b1;
                            r_job       <= J_EB;
                            r_state     <= S_EW;
                        end else begin
                            r_serr  <= n_res[31:0];
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_o_ok      <= 1'b1;
                        r_o_icpt    <= r_icpt;
                        r_o_slope   <= r_slope;
                        r_o_ierr    <= r_ierr;
                        r_o_serr    <= r_serr;
                        r_o_det     <= det_q32;
                        r_sum_w     <= '0;
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        r_sum_xx    <= '0;
                        r_sum_xy    <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_FAIL: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_o_ok      <= 1'b0;
                        r_o_icpt    <= '0;
                        r_o_slope   <= '0;
                        r_o_ierr    <= '0;
                        r_o_serr    <= '0;
                        r_o_det     <= DET_FAIL;
                        r_sum_w     <= '0;
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        r_sum_xx    <= '0;
                        r_sum_xy    <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `WLF_ASSERT_IMP(a_mul_free, i_clk, i_rst_n, r_mul_start, !i_mul_rsp.busy)
    `WLF_ASSERT_IMP(a_div_free, i_clk, i_rst_n, r_div_start, !i_div_rsp.busy)
    `WLF_ASSERT_IMP(a_load_slot, i_clk, i_rst_n, out_load, !r_out_valid && !r_term_v)
    `WLF_ASSERT_NXT(a_sums_clear, i_clk, i_rst_n, out_load, (r_sum_w == '0) && (r_sum_xx == '0))

endmodule

`default_nettype wire

>>> design/weighted_line_fit.sv
// Top level of the weighted straight-line fit
//
//   port group        dir   handshake      payload
//   point input       in    push / full    i_x_value, i_y_value, i_y_sigma, i_last_point
//   fit result        out   empty / pop    o_fit_ok, o_intercept, o_slope,
//                                          o_intercept_error, o_slope_error, o_determinant
//
// A point with nonzero sigma takes, in the back end (F = 16), the 3F+1 step weight
// divide plus seven multiplies on the shared multiplier. A zero-sigma point skips the
// square and the divide; a point past the set limit uses neither. A fit on the last
// point adds six products, two 128+F step divides, two 64+3F step divides and two
// 32 step square roots.
// The two-entry queue lets points be transferred while the back end works; a waiting
// result does not block accumulation of the next set. Reset is synchronous, active low.
`default_nettype none

module weighted_line_fit #(
    parameter int MAX_POINTS = wlf_pkg::MAX_POINTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic signed [31:0]  i_x_value,
    input  wire logic signed [31:0]  i_y_value,
    input  wire logic        [31:0]  i_y_sigma,
    input  wire logic                i_last_point,
    output logic                     empty,
    input  wire logic                pop,
    output logic                     o_fit_ok,
    output logic signed [31:0]       o_intercept,
    output logic signed [31:0]       o_slope,
    output logic        [31:0]       o_intercept_error,
    output logic        [31:0]       o_slope_error,
    output logic signed [63:0]       o_determinant
);
    import wlf_pkg::*;

    t_item    fr_item;
    t_item    q_item;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_empty;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;

    wlf_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .i_y_sigma   (i_y_sigma),
        .i_last_point(i_last_point),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_item      (fr_item)
    );

    wlf_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_item (fr_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_item (q_item)
    );

    wlf_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

    wlf_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    wlf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_item           (q_item),
        .o_mul_req        (mul_req),
        .i_mul_rsp        (mul_rsp),
        .o_div_req        (div_req),
        .i_div_rsp        (div_rsp),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_fit_ok         (o_fit_ok),
        .o_intercept      (o_intercept),
        .o_slope          (o_slope),
        .o_intercept_error(o_intercept_error),
        .o_slope_error    (o_slope_error),
        .o_determinant    (o_determinant)
    );

endmodule

`default_nettype wire
